@@ design/owm_pkg.sv @@
// ----------------------------------------------------------------------------
// owm_pkg
// Shared widths, types and helpers of the four-wheel omni mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package owm_pkg;

  localparam int SPEED_W  = 16;
  localparam int GAIN_W   = 16;
  localparam int NWHEEL   = 4;
  localparam int SUM_W    = SPEED_W + 2;
  localparam int RAW_W    = SUM_W + GAIN_W;
  localparam int MAG_W    = 32;
  localparam int Q_W      = SPEED_W + 1;
  localparam int SAT_W    = 20;
  localparam int GW_W     = 2 * SPEED_W;
  localparam int ACC_W    = GW_W + 2;
  localparam int ADDR_W   = 3;

  localparam int MIX_STG  = 4;
  localparam int DIV_STG  = 9;
  localparam int BACK_STG = 3;
  localparam int NSTG     = MIX_STG + DIV_STG + BACK_STG;

  // negative sign of each wheel's term, bit i = wheel i
  localparam logic [NWHEEL-1:0] NEG_Y = 4'b1010;
  localparam logic [NWHEEL-1:0] NEG_R = 4'b0110;

  // 1.0 in the raw product scale
  localparam logic [MAG_W-1:0] RAW_ONE = MAG_W'(1) << (SPEED_W - 1 + 14);
  localparam logic [MAG_W-1:0] RAW_HALF_LSB = MAG_W'(1) << 13;

  localparam logic signed [GAIN_W-1:0] GAIN_RST = 16'sd16384;

  typedef enum logic [ADDR_W-1:0] {
    REG_GAIN_W0 = 3'd0,
    REG_GAIN_W1 = 3'd1,
    REG_GAIN_W2 = 3'd2,
    REG_GAIN_W3 = 3'd3
  } reg_idx_t;

  typedef logic [NWHEEL-1:0][GAIN_W-1:0] gain_arr_t;

  typedef struct packed {
    logic                             stop;
    logic                             scaled;
    logic [NWHEEL-1:0]                neg;
    logic [NWHEEL-1:0][SPEED_W-1:0]   unsc;
  } side_t;

  typedef struct packed {
    side_t                            side;
    logic [NWHEEL-1:0][MAG_W-1:0]     mag;
    logic [MAG_W-1:0]                 max;
  } mix_out_t;

  typedef struct packed {
    side_t                            side;
    logic [NWHEEL-1:0][Q_W-1:0]       q;
  } div_out_t;

  typedef struct packed {
    logic             b;
    logic [MAG_W-1:0] r;
  } dstep_t;

  // one restoring step: shift the remainder left, subtract when it fits
  function automatic dstep_t div_step(input logic [MAG_W-1:0] r,
                                      input logic [MAG_W-1:0] d);
    dstep_t       o;
    logic [MAG_W:0] rs;
    rs = {r, 1'b0};
    if (rs >= {1'b0, d}) begin
      o.b = 1'b1;
      o.r = MAG_W'(rs - {1'b0, d});
    end else begin
      o.b = 1'b0;
      o.r = rs[MAG_W-1:0];
    end
    return o;
  endfunction

  // signed saturation of a magnitude and sign to Q1.15
  function automatic logic [SPEED_W-1:0] sat_mag(input logic [SAT_W-1:0] m,
                                                 input logic neg);
    logic [SPEED_W-1:0] o;
    if (neg) begin
      if (m >= SAT_W'(32768)) o = 16'h8000;
      else                    o = SPEED_W'(-m);
    end else begin
      if (m >= SAT_W'(32767)) o = 16'h7fff;
      else                    o = m[SPEED_W-1:0];
    end
    return o;
  endfunction

endpackage

`default_nettype wire

@@ design/owm_mix.sv @@
// ----------------------------------------------------------------------------
// owm_mix
// Wheel sums, gain products, magnitudes, peak search and unscaled rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module owm_mix (
  input  wire logic                                   clk,
  input  wire logic [owm_pkg::MIX_STG-1:0]            en,
  input  wire logic                                   stop,
  input  wire logic [owm_pkg::SPEED_W-1:0]            speed_x,
  input  wire logic [owm_pkg::SPEED_W-1:0]            speed_y,
  input  wire logic [owm_pkg::SPEED_W-1:0]            turn_cw,
  input  wire owm_pkg::gain_arr_t                     gain,
  output owm_pkg::mix_out_t                           mix_out
);

  logic [owm_pkg::NWHEEL-1:0][owm_pkg::SUM_W-1:0] s_r, s_nxt;
  logic [owm_pkg::NWHEEL-1:0][owm_pkg::RAW_W-1:0] raw_r, raw_nxt;
  logic [owm_pkg::NWHEEL-1:0][owm_pkg::MAG_W-1:0] mag_r, mag_nxt;
  logic [owm_pkg::NWHEEL-1:0]                     neg_r, neg_nxt;
  logic [owm_pkg::MAG_W-1:0]                      m01_r, m23_r, m01_nxt, m23_nxt;
  logic [owm_pkg::MIX_STG-2:0]                    stop_r;
  owm_pkg::mix_out_t                              out_r, out_nxt;

  always_comb begin
    logic signed [owm_pkg::SUM_W-1:0] x, y, r, ty, tr;
    x = owm_pkg::SUM_W'($signed(speed_x));
    y = owm_pkg::SUM_W'($signed(speed_y));
    r = owm_pkg::SUM_W'($signed(turn_cw));
    for (int i = 0; i < owm_pkg::NWHEEL; i++) begin
      ty = owm_pkg::NEG_Y[i] ? -y : y;
      tr = owm_pkg::NEG_R[i] ? -r : r;
      s_nxt[i] = x + ty + tr;
    end
  end

  always_comb begin
    logic signed [owm_pkg::RAW_W-1:0] p;
    for (int i = 0; i < owm_pkg::NWHEEL; i++) begin
      p = $signed(s_r[i]) * $signed(gain[i]);
      raw_nxt[i] = p;
    end
  end

  always_comb begin
    logic [owm_pkg::RAW_W-1:0] a;
    for (int i = 0; i < owm_pkg::NWHEEL; i++) begin
      neg_nxt[i] = raw_r[i][owm_pkg::RAW_W-1];
      a = neg_nxt[i] ? -raw_r[i] : raw_r[i];
      mag_nxt[i] = a[owm_pkg::MAG_W-1:0];
    end
    m01_nxt = (mag_nxt[0] >= mag_nxt[1]) ? mag_nxt[0] : mag_nxt[1];
    m23_nxt = (mag_nxt[2] >= mag_nxt[3]) ? mag_nxt[2] : mag_nxt[3];
  end

  always_comb begin
    logic [owm_pkg::MAG_W:0] rnd;
    out_nxt.max         = (m01_r >= m23_r) ? m01_r : m23_r;
    out_nxt.mag         = mag_r;
    out_nxt.side.stop   = stop_r[owm_pkg::MIX_STG-2];
    out_nxt.side.scaled = out_nxt.max > owm_pkg::RAW_ONE;
    out_nxt.side.neg    = neg_r;
    for (int i = 0; i < owm_pkg::NWHEEL; i++) begin
      rnd = {1'b0, mag_r[i]} + {1'b0, owm_pkg::RAW_HALF_LSB};
      out_nxt.side.unsc[i] = owm_pkg::sat_mag(owm_pkg::SAT_W'(rnd >> 14), neg_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s_r       <= s_nxt;
      stop_r[0] <= stop;
    end
    if (en[1]) begin
      raw_r     <= raw_nxt;
      stop_r[1] <= stop_r[0];
    end
    if (en[2]) begin
      mag_r     <= mag_nxt;
      neg_r     <= neg_nxt;
      m01_r     <= m01_nxt;
      m23_r     <= m23_nxt;
      stop_r[2] <= stop_r[1];
    end
    if (en[3]) begin
      out_r     <= out_nxt;
    end
  end

  assign mix_out = out_r;

endmodule

`default_nettype wire

@@ design/owm_div.sv @@
// ----------------------------------------------------------------------------
// owm_div
// Pipelined restoring divider: |w| * 2^16 / max for all four wheels.
// ----------------------------------------------------------------------------
`default_nettype none

module owm_div (
  input  wire logic                         clk,
  input  wire logic [owm_pkg::DIV_STG-1:0]  en,
  input  wire owm_pkg::mix_out_t            mix_in,
  output owm_pkg::div_out_t                 div_out
);

  owm_pkg::side_t                                       side_r [owm_pkg::DIV_STG];
  logic [owm_pkg::MAG_W-1:0]                            d_r    [owm_pkg::DIV_STG];
  logic [owm_pkg::NWHEEL-1:0][owm_pkg::MAG_W-1:0]       rem_r  [owm_pkg::DIV_STG];
  logic [owm_pkg::NWHEEL-1:0][owm_pkg::Q_W-1:0]         q_r    [owm_pkg::DIV_STG];

  for (genvar k = 0; k < owm_pkg::DIV_STG; k++) begin : g_stg
    logic [owm_pkg::NWHEEL-1:0][owm_pkg::MAG_W-1:0] rem_nxt;
    logic [owm_pkg::NWHEEL-1:0][owm_pkg::Q_W-1:0]   q_nxt;

    if (k == 0) begin : g_first
      always_comb begin
        owm_pkg::dstep_t          st;
        logic                     b0;
        logic [owm_pkg::MAG_W-1:0] r0;
        for (int i = 0; i < owm_pkg::NWHEEL; i++) begin
          b0 = mix_in.mag[i] >= mix_in.max;
          r0 = b0 ? mix_in.mag[i] - mix_in.max : mix_in.mag[i];
          st = owm_pkg::div_step(r0, mix_in.max);
          rem_nxt[i] = st.r;
          q_nxt[i]   = {{(owm_pkg::Q_W-2){1'b0}}, b0, st.b};
        end
      end
      always_ff @(posedge clk) begin
        if (en[k]) begin
          side_r[k] <= mix_in.side;
          d_r[k]    <= mix_in.max;
          rem_r[k]  <= rem_nxt;
          q_r[k]    <= q_nxt;
        end
      end
    end else if (k == owm_pkg::DIV_STG - 1) begin : g_last
      always_comb begin
        owm_pkg::dstep_t st;
        for (int i = 0; i < owm_pkg::NWHEEL; i++) begin
          st = owm_pkg::div_step(rem_r[k-1][i], d_r[k-1]);
          rem_nxt[i] = st.r;
          q_nxt[i]   = {q_r[k-1][i][owm_pkg::Q_W-2:0], st.b};
        end
      end
      always_ff @(posedge clk) begin
        if (en[k]) begin
          side_r[k] <= side_r[k-1];
          d_r[k]    <= d_r[k-1];
          rem_r[k]  <= rem_nxt;
          q_r[k]    <= q_nxt;
        end
      end
    end else begin : g_mid
      always_comb begin
        owm_pkg::dstep_t s1, s2;
        for (int i = 0; i < owm_pkg::NWHEEL; i++) begin
          s1 = owm_pkg::div_step(rem_r[k-1][i], d_r[k-1]);
          s2 = owm_pkg::div_step(s1.r, d_r[k-1]);
          rem_nxt[i] = s2.r;
          q_nxt[i]   = {q_r[k-1][i][owm_pkg::Q_W-3:0], s1.b, s2.b};
        end
      end
      always_ff @(posedge clk) begin
        if (en[k]) begin
          side_r[k] <= side_r[k-1];
          d_r[k]    <= d_r[k-1];
          rem_r[k]  <= rem_nxt;
          q_r[k]    <= q_nxt;
        end
      end
    end
  end

  assign div_out.side = side_r[owm_pkg::DIV_STG-1];
  assign div_out.q    = q_r[owm_pkg::DIV_STG-1];

endmodule

`default_nettype wire

@@ design/owm_back.sv @@
// ----------------------------------------------------------------------------
// owm_back
// Wheel selection and rounding, then back-computation of body speeds.
// ----------------------------------------------------------------------------
`default_nettype none

module owm_back (
  input  wire logic                                        clk,
  input  wire logic [owm_pkg::BACK_STG-1:0]                en,
  input  wire owm_pkg::div_out_t                           div_in,
  input  wire owm_pkg::gain_arr_t                          gain,
  output logic [owm_pkg::NWHEEL-1:0][owm_pkg::SPEED_W-1:0] wheel,
  output logic [2:0][owm_pkg::SPEED_W-1:0]                 achieved
);

  logic [owm_pkg::NWHEEL-1:0][owm_pkg::SPEED_W-1:0] w0_r, w0_nxt, w1_r, w2_r;
  logic [owm_pkg::NWHEEL-1:0][owm_pkg::GW_W-1:0]    gw_r, gw_nxt;
  logic [2:0][owm_pkg::SPEED_W-1:0]                 ach_r, ach_nxt;

  always_comb begin
    logic [owm_pkg::Q_W:0] qr;
    for (int i = 0; i < owm_pkg::NWHEEL; i++) begin
      qr = ({1'b0, div_in.q[i]} + 1'b1) >> 1;
      if (div_in.side.stop)
        w0_nxt[i] = '0;
      else if (div_in.side.scaled)
        w0_nxt[i] = owm_pkg::sat_mag(owm_pkg::SAT_W'(qr), div_in.side.neg[i]);
      else
        w0_nxt[i] = div_in.side.unsc[i];
    end
  end

  always_comb begin
    logic signed [owm_pkg::GW_W-1:0] p;
    for (int i = 0; i < owm_pkg::NWHEEL; i++) begin
      p = $signed(gain[i]) * $signed(w0_r[i]);
      gw_nxt[i] = p;
    end
  end

  always_comb begin
    logic signed [owm_pkg::ACC_W-1:0] ax, ay, ar, g;
    logic [owm_pkg::ACC_W-1:0]        m;
    logic                             ng;
    ax = '0;
    ay = '0;
    ar = '0;
    for (int i = 0; i < owm_pkg::NWHEEL; i++) begin
      g  = owm_pkg::ACC_W'($signed(gw_r[i]));
      ax = ax + g;
      ay = owm_pkg::NEG_Y[i] ? ay - g : ay + g;
      ar = owm_pkg::NEG_R[i] ? ar - g : ar + g;
    end
    for (int a = 0; a < 3; a++) begin
      g  = (a == 0) ? ax : ((a == 1) ? ay : ar);
      ng = g[owm_pkg::ACC_W-1];
      m  = ng ? -g : g;
      m  = (m + (owm_pkg::ACC_W'(1) << 15)) >> 16;
      ach_nxt[a] = owm_pkg::sat_mag(owm_pkg::SAT_W'(m), ng);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) w0_r <= w0_nxt;
    if (en[1]) begin
      gw_r <= gw_nxt;
      w1_r <= w0_r;
    end
    if (en[2]) begin
      ach_r <= ach_nxt;
      w2_r  <= w1_r;
    end
  end

  assign wheel    = w2_r;
  assign achieved = ach_r;

endmodule

`default_nettype wire

@@ design/omni_wheel_mixer.sv @@
// ----------------------------------------------------------------------------
// omni_wheel_mixer
// Inverse-kinematics mixer for a four-wheel omni base.
// ----------------------------------------------------------------------------
// Takes one command per cycle while in_tready is high and returns one result
// per command. The depth is set by the 17-bit normalizing division, done two
// quotient bits per stage (one in the last) in nine stages, plus four mixing
// stages and three back-computation stages. Each stage holds its data while
// the next one is full and cannot advance, so stalls lose nothing. The user
// must write gains through cfg_* only while the block is idle; the block
// itself does not enforce this.
`default_nettype none

module omni_wheel_mixer (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [47:0]                   in_tdata,   // speed_x, speed_y, turn_cw
  input  wire logic                          in_tuser,   // func (1 = stop)
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [111:0]                       out_tdata,  // wheel_0..3_drive,
                                                         // achieved_x, _y, _turn
  input  wire logic                          cfg_we,
  input  wire logic [owm_pkg::ADDR_W-1:0]    cfg_addr,
  input  wire logic [owm_pkg::GAIN_W-1:0]    cfg_wdata
);

  owm_pkg::gain_arr_t                                gain_r;
  logic [owm_pkg::NSTG-1:0]                          v_r, v_nxt, rdy;
  owm_pkg::mix_out_t                                 mix_o;
  owm_pkg::div_out_t                                 div_o;
  logic [owm_pkg::NWHEEL-1:0][owm_pkg::SPEED_W-1:0]  wheel;
  logic [2:0][owm_pkg::SPEED_W-1:0]                  achieved;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < owm_pkg::NWHEEL; i++) gain_r[i] <= owm_pkg::GAIN_RST;
    end else if (cfg_we) begin
      unique case (owm_pkg::reg_idx_t'(cfg_addr))
        owm_pkg::REG_GAIN_W0: gain_r[0] <= cfg_wdata;
        owm_pkg::REG_GAIN_W1: gain_r[1] <= cfg_wdata;
        owm_pkg::REG_GAIN_W2: gain_r[2] <= cfg_wdata;
        owm_pkg::REG_GAIN_W3: gain_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    rdy[owm_pkg::NSTG-1] = ~v_r[owm_pkg::NSTG-1] | out_tready;
    for (int k = owm_pkg::NSTG - 2; k >= 0; k--) rdy[k] = ~v_r[k] | rdy[k+1];
    v_nxt[0] = rdy[0] ? in_tvalid : v_r[0];
    for (int k = 1; k < owm_pkg::NSTG; k++) v_nxt[k] = rdy[k] ? v_r[k-1] : v_r[k];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else        v_r <= v_nxt;
  end

  owm_mix u_mix (
    .clk     (clk),
    .en      (rdy[owm_pkg::MIX_STG-1:0]),
    .stop    (in_tuser),
    .speed_x (in_tdata[15:0]),
    .speed_y (in_tdata[31:16]),
    .turn_cw (in_tdata[47:32]),
    .gain    (gain_r),
    .mix_out (mix_o)
  );

  owm_div u_div (
    .clk     (clk),
    .en      (rdy[owm_pkg::MIX_STG+owm_pkg::DIV_STG-1:owm_pkg::MIX_STG]),
    .mix_in  (mix_o),
    .div_out (div_o)
  );

  owm_back u_back (
    .clk      (clk),
    .en       (rdy[owm_pkg::NSTG-1:owm_pkg::MIX_STG+owm_pkg::DIV_STG]),
    .div_in   (div_o),
    .gain     (gain_r),
    .wheel    (wheel),
    .achieved (achieved)
  );

  assign in_tready  = rdy[0];
  assign out_tvalid = v_r[owm_pkg::NSTG-1];
  assign out_tdata  = {achieved[2], achieved[1], achieved[0],
                       wheel[3], wheel[2], wheel[1], wheel[0]};

  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (&v_r) && !out_tready)
    else $error("input blocked while pipeline has a bubble");

  a_gain0_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && cfg_addr == owm_pkg::REG_GAIN_W0 |=> gain_r[0] == $past(cfg_wdata))
    else $error("gain 0 write lost");

  a_zero_wheels: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[63:0] == 64'd0 |-> out_tdata[111:64] == 48'd0)
    else $error("nonzero body speed from idle wheels");

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Testbench of the four-wheel omni mixer: directed and random drive/stop
// commands over several gain settings, each result checked field by field
// against a behavioral model of the mixer, with random stalls on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [47:0] in_tdata;
  logic in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [111:0] out_tdata;
  logic cfg_we;
  logic [owm_pkg::ADDR_W-1:0] cfg_addr;
  logic [owm_pkg::GAIN_W-1:0] cfg_wdata;

  omni_wheel_mixer uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  localparam int LATENCY = 16;
  localparam int LONG_HOLD = 60;
  // index past the last gain register
  localparam logic [owm_pkg::ADDR_W-1:0] BAD_IDX = 3'd5;

  logic signed [15:0] gains [owm_pkg::NWHEEL];
  logic [111:0] wheel_results_q [$];
  int errors;
  bit idle_en;
  int hold_cycles;
  int long_hold;
  logic long_start;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic longint sat16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint round_shift(input longint v, input int sh);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (longint'(1) << (sh - 1))) >>> sh;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint norm_div(input longint w, input longint d);
    longint m, r, q;
    m = (w < 0) ? -w : w;
    r = m;
    q = 0;
    if (r >= d) begin
      q = 1;
      r -= d;
    end
    for (int k = 0; k < 16; k++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r -= d;
        q |= 1;
      end
    end
    q = (q + 1) >> 1;
    return (w < 0) ? -q : q;
  endfunction

  // expected wheels and achieved speeds for one drive or stop command
  function automatic logic [111:0] mix_command(input bit stop_cmd,
                                                input logic [47:0] speeds);
    longint x, y, r, s, maxm, m, ax, ay, ar, gw;
    longint raw [owm_pkg::NWHEEL];
    longint wh [owm_pkg::NWHEEL];
    logic [111:0] res;
    res = '0;
    if (stop_cmd) return res;
    x = longint'($signed(speeds[15:0]));
    y = longint'($signed(speeds[31:16]));
    r = longint'($signed(speeds[47:32]));
    maxm = 0;
    for (int i = 0; i < owm_pkg::NWHEEL; i++) begin
      s = x + (owm_pkg::NEG_Y[i] ? -y : y) + (owm_pkg::NEG_R[i] ? -r : r);
      raw[i] = s * longint'(gains[i]);
      m = (raw[i] < 0) ? -raw[i] : raw[i];
      if (m > maxm) maxm = m;
    end
    ax = 0; ay = 0; ar = 0;
    for (int i = 0; i < owm_pkg::NWHEEL; i++) begin
      if (maxm > (longint'(1) << 29)) wh[i] = sat16(norm_div(raw[i], maxm));
      else wh[i] = sat16(round_shift(raw[i], 14));
      gw = longint'(gains[i]) * wh[i];
      ax += gw;
      ay += owm_pkg::NEG_Y[i] ? -gw : gw;
      ar += owm_pkg::NEG_R[i] ? -gw : gw;
      res[16*i +: 16] = wh[i][15:0];
    end
    res[64 +: 16] = 16'(sat16(round_shift(ax, 16)));
    res[80 +: 16] = 16'(sat16(round_shift(ay, 16)));
    res[96 +: 16] = 16'(sat16(round_shift(ar, 16)));
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] exp_v);
    $display("mismatch %s: got %h expected %h", what, got, exp_v);
    errors++;
  endtask

  // long receiver stall
  always @(posedge clk) begin
    if (!rst_n) long_hold <= 0;
    else if (long_start) long_hold <= LONG_HOLD;
    else if (long_hold > 0) long_hold <= long_hold - 1;
  end

  // receiver stall and result check
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_cycles <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (wheel_results_q.size() == 0) begin
          report_mismatch("unexpected transfer", out_tdata[15:0], 16'h0);
        end else begin
          logic [111:0] e;
          e = wheel_results_q.pop_front();
          for (int f = 0; f < 7; f++)
            if (out_tdata[16*f +: 16] !== e[16*f +: 16])
              report_mismatch($sformatf("field %0d", f), out_tdata[16*f +: 16],
                              e[16*f +: 16]);
        end
      end
      if (long_hold > 0) begin
        out_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_tready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        hold_cycles <= $urandom_range(0, 3);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_command(input bit stop_cmd, input logic [47:0] speeds);
    int gap;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= stop_cmd;
    in_tdata <= speeds;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    wheel_results_q.push_back(mix_command(stop_cmd, speeds));
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (wheel_results_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_gain(input logic [owm_pkg::ADDR_W-1:0] idx,
                            input logic [15:0] g);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= g;
    @(posedge clk);
    if (idx <= owm_pkg::REG_GAIN_W3) gains[idx[1:0]] = g;
  endtask

  task automatic set_gains(input logic [15:0] g0, g1, g2, g3);
    drain();
    write_gain(owm_pkg::REG_GAIN_W0, g0);
    write_gain(owm_pkg::REG_GAIN_W1, g1);
    write_gain(owm_pkg::REG_GAIN_W2, g2);
    write_gain(owm_pkg::REG_GAIN_W3, g3);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] rand_speed();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 400)) - 16'd200;
      3: return 16'($urandom_range(0, 8191)) - 16'd4096;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed;
    logic [15:0] ext [6] = '{16'h0000, 16'h7fff, 16'h8000, 16'h0001, 16'hffff, 16'h2000};
    send_command(1'b0, 48'h0);
    for (int i = 0; i < 6; i++) send_command(1'b0, {16'h0, 16'h0, ext[i]});
    send_command(1'b0, {16'h0, 16'h7fff, 16'h0});
    send_command(1'b0, {16'h8000, 16'h0, 16'h0});
    send_command(1'b0, {16'h7fff, 16'h7fff, 16'h7fff});
    send_command(1'b0, {16'h8000, 16'h8000, 16'h8000});
    send_command(1'b0, {16'h1000, 16'h1000, 16'h1000});
    send_command(1'b1, {16'h7fff, 16'h1234, 16'h8000});
    send_command(1'b0, {16'h2000, 16'hf000, 16'h0800});
    send_command(1'b1, 48'h0);
    send_command(1'b0, {16'hffff, 16'hffff, 16'hffff});
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++)
      send_command($urandom_range(0, 15) == 0,
                   {rand_speed(), rand_speed(), rand_speed()});
  endtask

  task automatic test_backpressure;
    drain();
    long_start <= 1'b1;
    @(posedge clk);
    long_start <= 1'b0;
    test_random(40);
    drain();
  endtask

  task automatic test_gain_settings;
    set_gains(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    test_random(120);
    set_gains(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    test_random(120);
    set_gains(16'h0000, 16'h4000, 16'h8000, 16'h7fff);
    test_random(80);
    set_gains(16'h0001, 16'hffff, 16'h2000, 16'hc000);
    test_random(80);
    drain();
    write_gain(BAD_IDX, 16'h1234);
    cfg_we <= 1'b0;
    for (int k = 0; k < 3; k++) begin
      set_gains(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      test_random(80);
    end
    set_gains(16'h4000, 16'h4000, 16'h4000, 16'h4000);
  endtask

  initial begin
    errors = 0;
    idle_en = 1'b1;
    for (int i = 0; i < owm_pkg::NWHEEL; i++) gains[i] = owm_pkg::GAIN_RST;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= 1'b0;
    cfg_we <= 1'b0;
    cfg_addr <= '0;
    cfg_wdata <= '0;
    long_start <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(100);
    test_backpressure();
    test_gain_settings();
    idle_en = 1'b0;
    test_random(150);
    drain();
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

`default_nettype wire

@@ omni_wheel_mixer.f @@
design/owm_pkg.sv
design/owm_mix.sv
design/owm_div.sv
design/owm_back.sv
design/omni_wheel_mixer.sv
bench/tb.sv
